FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MTFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MTFD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MTFD_ASSERT(label, clk, rst_n, prop, msg)

`define MTFD_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: design/mtfd_pkg.sv
// ---------------------------------------------------------------------------
// mtfd_pkg
// Shared types and constants of the multitap feedback delay.
// ---------------------------------------------------------------------------
package mtfd_pkg;

    localparam int DELAY_W    = 15;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TAP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_TAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_DECAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN    = 3'd5;

    localparam int FIRST_TAP_RST  = 4327;
    localparam int SECOND_TAP_RST = 11003;
    localparam int THIRD_TAP_RST  = 19013;

    localparam logic [GAIN_W-1:0] LP_GAIN_RST  = 8'd50;
    localparam logic [GAIN_W-1:0] LP_DECAY_RST = 8'd206;
    localparam logic [GAIN_W-1:0] FB_GAIN_RST  = 8'd200;

    typedef logic signed [31:0] sample_t;
    typedef logic signed [15:0] tap_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tape_ctl_t;

endpackage

FILE: design/mtfd_tape.sv
// ---------------------------------------------------------------------------
// mtfd_tape
// Single-port delay tape with registered read and a fill count that makes
// never-written entries read as zero.
// ---------------------------------------------------------------------------
module mtfd_tape #(
    parameter int TAPE_DEPTH = 32768
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtfd_pkg::tape_ctl_t           ctl,
    input  logic [$clog2(TAPE_DEPTH)-1:0] addr,
    input  mtfd_pkg::tap_t                wdata,
    output mtfd_pkg::tap_t                rdata
);
    import mtfd_pkg::*;

    localparam int FW = $clog2(TAPE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(TAPE_DEPTH);

    tap_t            mem [TAPE_DEPTH];
    tap_t            q_reg;
    logic            rd_ok_reg;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   addr_x;

    assign addr_x = FW'(addr);

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        else if (ctl.rd_en)
        begin
            q_reg <= mem[addr];
        end
    end

    // writes run through the tape in address order, so entries below the
    // fill count are exactly the written ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en && (fill_reg != FILL_MAX))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (!ctl.wr_en && ctl.rd_en)
            begin
                rd_ok_reg <= (addr_x < fill_reg);
            end
        end
    end

    assign rdata = rd_ok_reg ? q_reg : '0;

endmodule

FILE: design/multitap_feedback_delay.sv
// ---------------------------------------------------------------------------
// multitap_feedback_delay
// Three-tap feedback delay on a single-port tape with a one-pole lowpass.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries dry_sample; output channel
//   out_valid/out_stall carries wet_sample. A transfer happens when valid
//   is high and stall low. Configuration uses cfg_valid/cfg_ready with
//   cfg_index and cfg_data; indexes beyond the register list are ignored.
//   A taken sample runs S_RD1, S_RD2, S_RD3, S_MIX, S_WR; out_valid rises
//   as it leaves S_WR, and only then is the next one taken, as set by the
//   single tape port (three tap reads and one write) and the two multiply
//   stages. Writing a tap delay starts a modulo reduction against the tape
//   depth; cfg_ready and input acceptance are held off for that time.
//   Reset: tape reads as zero through a fill count, so no clearing pass is
//   run; registers return to their defaults and the block is ready at once.
//   Stall: a result waits in the output register; the next sample is still
//   taken and runs until its tape write, where it waits for the output.
// ---------------------------------------------------------------------------
module multitap_feedback_delay #(
    parameter int TAPE_DEPTH = 32768
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  mtfd_pkg::sample_t                      dry_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output mtfd_pkg::sample_t                      wet_sample,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mtfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mtfd_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mtfd_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(TAPE_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(TAPE_DEPTH - 1);
    localparam logic [AW-1:0] D0_INIT = AW'(FIRST_TAP_RST % TAPE_DEPTH);
    localparam logic [AW-1:0] D1_INIT = AW'(SECOND_TAP_RST % TAPE_DEPTH);
    localparam logic [AW-1:0] D2_INIT = AW'(THIRD_TAP_RST % TAPE_DEPTH);
    localparam int            RED_SH  = DELAY_W + AW;
    localparam longint        RECIP_L = ((longint'(1) << RED_SH) + longint'(TAPE_DEPTH) - 1)
                                        / longint'(TAPE_DEPTH);
    localparam logic [DELAY_W+1:0] RECIP = (DELAY_W + 2)'(RECIP_L);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MIX,
        S_WR
    } state_t;

    state_t                  state_reg;
    logic [AW-1:0]           dly0_reg;
    logic [AW-1:0]           dly1_reg;
    logic [AW-1:0]           dly2_reg;
    logic [GAIN_W-1:0]       lp_gain_reg;
    logic [GAIN_W-1:0]       lp_decay_reg;
    logic [GAIN_W-1:0]       fb_gain_reg;
    logic                    red_busy_reg;
    logic [CFG_IDX_W-1:0]    red_sel_reg;
    logic                    red_k_reg;
    logic [DELAY_W-1:0]      red_r_reg;
    logic [DELAY_W-1:0]      red_q_reg;
    logic [AW-1:0]           wp_reg;
    tap_t                    filt_reg;
    tap_t                    acc_reg;
    sample_t                 dry_reg;
    logic signed [24:0]      p_in_reg;
    logic signed [24:0]      p_dec_reg;
    logic signed [24:0]      p_fb_reg;
    sample_t                 res_reg;
    logic                    out_valid_reg;
    sample_t                 wet_reg;

    logic                    in_take;
    logic                    cfg_take;
    logic                    out_free;
    logic [2*DELAY_W+1:0]    red_prod;
    logic [DELAY_W-1:0]      red_q_next;
    logic [DELAY_W+AW:0]     red_qn;
    logic [DELAY_W+AW:0]     red_rem;
    logic [AW-1:0]           red_d;
    logic [AW-1:0]           cur_dly;
    logic [AW:0]             idx_diff;
    logic [AW:0]             idx_wrap;
    logic [AW-1:0]           tap_addr;
    tape_ctl_t               tape_ctl;
    logic [AW-1:0]           tape_addr;
    tap_t                    tape_q;
    tap_t                    tap_sh;
    tap_t                    wet_sum;
    logic signed [24:0]      p_in_next;
    logic signed [24:0]      p_dec_next;
    logic signed [25:0]      mix_sum;
    logic signed [25:0]      mix_sh;
    tap_t                    lp_next;
    logic signed [24:0]      p_fb_next;
    logic signed [33:0]      res_sum;
    sample_t                 res_next;
    logic signed [32:0]      fb_sum;
    tap_t                    fb_next;
    logic [AW-1:0]           wp_next;

    assign in_stall  = (state_reg != S_IDLE) || red_busy_reg;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = !red_busy_reg;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign wet_sample = wet_reg;

    // tap delay modulo tape depth: quotient by reciprocal, then subtract
    assign red_prod   = {{(DELAY_W + 2){1'b0}}, red_r_reg} * {{DELAY_W{1'b0}}, RECIP};
    assign red_q_next = DELAY_W'(red_prod >> RED_SH);
    assign red_qn     = {{(AW + 1){1'b0}}, red_q_reg} * {{DELAY_W{1'b0}}, DEPTH_X};
    assign red_rem    = {{(AW + 1){1'b0}}, red_r_reg} - red_qn;
    assign red_d      = red_rem[AW-1:0];

    always_comb
    begin
        case (state_reg)
            S_IDLE:  cur_dly = dly0_reg;
            S_RD1:   cur_dly = dly1_reg;
            default: cur_dly = dly2_reg;
        endcase
    end

    assign idx_diff = {1'b0, wp_reg} - {1'b0, cur_dly};
    assign idx_wrap = idx_diff + DEPTH_X;
    assign tap_addr = idx_diff[AW] ? idx_wrap[AW-1:0] : idx_diff[AW-1:0];

    always_comb
    begin
        tape_ctl.rd_en = 1'b0;
        tape_ctl.wr_en = 1'b0;
        tape_addr      = tap_addr;
        case (state_reg)
            S_IDLE:  tape_ctl.rd_en = in_take;
            S_RD1:   tape_ctl.rd_en = 1'b1;
            S_RD2:   tape_ctl.rd_en = 1'b1;
            S_WR:
            begin
                tape_ctl.wr_en = out_free;
                tape_addr      = wp_reg;
            end
            default: tape_ctl.rd_en = 1'b0;
        endcase
    end

    mtfd_tape #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tape_ctl),
        .addr  (tape_addr),
        .wdata (fb_next),
        .rdata (tape_q)
    );

    assign tap_sh     = tape_q >>> 2;
    assign wet_sum    = acc_reg + tap_sh;
    assign p_in_next  = {{9{wet_sum[15]}}, wet_sum} * {17'd0, lp_gain_reg};
    assign p_dec_next = {{9{filt_reg[15]}}, filt_reg} * {17'd0, lp_decay_reg};

    assign mix_sum = {p_in_reg[24], p_in_reg} + {p_dec_reg[24], p_dec_reg};
    assign mix_sh  = mix_sum >>> 8;

    always_comb
    begin
        if (mix_sh > 26'sd32767)
        begin
            lp_next = 16'sh7FFF;
        end
        else if (mix_sh < -26'sd32768)
        begin
            lp_next = 16'sh8000;
        end
        else
        begin
            lp_next = mix_sh[15:0];
        end
    end

    assign p_fb_next = {{9{lp_next[15]}}, lp_next} * {17'd0, fb_gain_reg};
    assign res_sum   = {{2{dry_reg[31]}}, dry_reg} + {{17{lp_next[15]}}, lp_next, 1'b0};

    always_comb
    begin
        if (res_sum > 34'sh7FFF_FFFF)
        begin
            res_next = 32'sh7FFF_FFFF;
        end
        else if (res_sum < -34'sh8000_0000)
        begin
            res_next = 32'sh8000_0000;
        end
        else
        begin
            res_next = res_sum[31:0];
        end
    end

    assign fb_sum = {{2{dry_reg[31]}}, dry_reg[31:1]} + {{16{p_fb_reg[24]}}, p_fb_reg[24:8]};

    always_comb
    begin
        if (fb_sum > 33'sd32767)
        begin
            fb_next = 16'sh7FFF;
        end
        else if (fb_sum < -33'sd32768)
        begin
            fb_next = 16'sh8000;
        end
        else
        begin
            fb_next = fb_sum[15:0];
        end
    end

    assign wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dly0_reg      <= D0_INIT;
            dly1_reg      <= D1_INIT;
            dly2_reg      <= D2_INIT;
            lp_gain_reg   <= LP_GAIN_RST;
            lp_decay_reg  <= LP_DECAY_RST;
            fb_gain_reg   <= FB_GAIN_RST;
            red_busy_reg  <= 1'b0;
            red_sel_reg   <= CFG_FIRST_TAP;
            red_k_reg     <= 1'b0;
            red_r_reg     <= '0;
            red_q_reg     <= '0;
            wp_reg        <= '0;
            filt_reg      <= '0;
            acc_reg       <= '0;
            dry_reg       <= '0;
            p_in_reg      <= '0;
            p_dec_reg     <= '0;
            p_fb_reg      <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            wet_reg       <= '0;
        end
        else
        begin
            if (cfg_take)
            begin
                case (cfg_index)
                    CFG_FIRST_TAP, CFG_SECOND_TAP, CFG_THIRD_TAP:
                    begin
                        red_busy_reg <= 1'b1;
                        red_sel_reg  <= cfg_index;
                        red_k_reg    <= 1'b1;
                        red_r_reg    <= cfg_data[DELAY_W-1:0];
                    end
                    CFG_LP_GAIN:  lp_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_LP_DECAY: lp_decay_reg <= cfg_data[GAIN_W-1:0];
                    CFG_FB_GAIN:  fb_gain_reg  <= cfg_data[GAIN_W-1:0];
                    default:      red_busy_reg <= 1'b0;
                endcase
            end
            else if (red_busy_reg)
            begin
                if (red_k_reg)
                begin
                    red_q_reg <= red_q_next;
                    red_k_reg <= 1'b0;
                end
                else
                begin
                    red_busy_reg <= 1'b0;
                    case (red_sel_reg)
                        CFG_FIRST_TAP:  dly0_reg <= red_d;
                        CFG_SECOND_TAP: dly1_reg <= red_d;
                        default:        dly2_reg <= red_d;
                    endcase
                end
            end

            if (out_valid_reg && !out_stall && (state_reg != S_WR))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        dry_reg   <= dry_sample;
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                begin
                    acc_reg   <= tap_sh;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    acc_reg   <= wet_sum;
                    state_reg <= S_RD3;
                end
                S_RD3:
                begin
                    p_in_reg  <= p_in_next;
                    p_dec_reg <= p_dec_next;
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    filt_reg  <= lp_next;
                    p_fb_reg  <= p_fb_next;
                    res_reg   <= res_next;
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (out_free)
                    begin
                        wp_reg        <= wp_next;
                        out_valid_reg <= 1'b1;
                        wet_reg       <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `MTFD_ASSERT(a_take_read, clk, rst_n, in_take |=> (state_reg == S_RD1), "take without read")
    `MTFD_ASSERT(a_write_result, clk, rst_n, tape_ctl.wr_en |=> out_valid_reg, "no result")
    `MTFD_ASSERT_NEVER(a_wp_range, clk, rst_n, {1'b0, wp_reg} >= DEPTH_X, "wp out of range")

endmodule
